[rtl/bb_pkg.sv]
`timescale 1ns / 1ps

package bb_pkg;

  // Register map: index taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int ROW_W        = 13;
  localparam int PIX_W        = 8;
  localparam int SUM_W        = 10;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd768;

  // Entries in the front-to-back request queue
  localparam int QUEUE_DEPTH = 4;

  // Per-request control bits handed from the front to the back
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } bb_flags_t;

  // floor(s / 3) for s <= 765: multiply by 683 / 2048
  function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] s);
    logic [20:0] p;
    p = 21'(s) * 21'd683;
    return p[18:11];
  endfunction

endpackage

[rtl/box_blur_3x3_stream_top.sv]
`timescale 1ns / 1ps

// 3x3 box blur over a raster-order stream of 8-bit pixels, taken one per clock
// unless stalled. A result passes the queue, stage 1 and output register after
// the pixel that completes its window, for every pixel from column 2 of row 2 on,
// and is the truncated mean of three truncated row means centred one row and one
// column back. The rate is set by one read and one write per cycle on the single
// line store (LINE_WIDTH entries of two bytes), which needs no clearing pass after
// reset. A four-entry request queue separates the position tracking from the
// line-store side, so either stream can stall on its own. image_width (offset 0)
// and image_height (offset 4) should only be written while the block is idle.

module box_blur_3x3_stream_top #(
  parameter int LINE_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Pixel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bb_pkg::PIX_W-1:0]      pixel_i,
  input  logic                          frame_start_i,
  // Blurred output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bb_pkg::PIX_W-1:0]      blurred_o,
  output logic                          row_end_o,
  output logic                          frame_end_o
);

  localparam int AW = $clog2(LINE_WIDTH);
  localparam int QW = AW + bb_pkg::PIX_W + $bits(bb_pkg::bb_flags_t);

  logic [bb_pkg::CFG_WIDTH_W-1:0]  width_q;
  logic [bb_pkg::CFG_HEIGHT_W-1:0] height_q;
  logic                            cfg_wr, accept, push, q_full, q_valid, pop;
  logic [AW-1:0]                   f_col, b_col;
  logic [bb_pkg::PIX_W-1:0]        f_hm, b_hm;
  bb_pkg::bb_flags_t               f_flags, b_flags;
  logic [QW-1:0]                   q_in, q_out;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb_pkg::WIDTH_RESET;
      height_q <= bb_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bb_pkg::REG_WIDTH:  width_q  <= pwdata[bb_pkg::CFG_WIDTH_W-1:0];
        bb_pkg::REG_HEIGHT: height_q <= pwdata[bb_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bb_pkg::REG_WIDTH:  prdata = 32'(width_q);
      bb_pkg::REG_HEIGHT: prdata = 32'(height_q);
      default:            prdata = '0;
    endcase
  end

  // Input request handshake
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  bb_front #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .width_i       (width_q),
    .height_i      (height_q),
    .accept_i      (accept),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .col_o         (f_col),
    .hmean_o       (f_hm),
    .flags_o       (f_flags)
  );

  assign q_in = {f_col, f_hm, f_flags};

  bb_queue #(
    .W (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_out)
  );

  assign {b_col, b_hm, b_flags} = q_out;

  bb_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_col_i   (b_col),
    .req_hmean_i (b_hm),
    .req_flags_i (b_flags),
    .req_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blurred_o   (blurred_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule

[rtl/bb_front.sv]
`timescale 1ns / 1ps

module bb_front #(
  parameter int LINE_WIDTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [bb_pkg::CFG_WIDTH_W-1:0]         width_i,
  input  logic [bb_pkg::CFG_HEIGHT_W-1:0]        height_i,
  input  logic                                   accept_i,
  input  logic [bb_pkg::PIX_W-1:0]               pixel_i,
  input  logic                                   frame_start_i,
  output logic                                   push_o,
  output logic [$clog2(LINE_WIDTH)-1:0]          col_o,
  output logic [bb_pkg::PIX_W-1:0]               hmean_o,
  output bb_pkg::bb_flags_t                      flags_o
);

  localparam int AW = $clog2(LINE_WIDTH);
  localparam int WW = $clog2(LINE_WIDTH + 1);
  localparam int EW = (WW > bb_pkg::CFG_WIDTH_W) ? WW : bb_pkg::CFG_WIDTH_W;

  logic [AW-1:0]                col_q, col_d, col_base, col_cur, last_idx;
  logic [bb_pkg::ROW_W-1:0]     row_q, row_d, row_base, row_last;
  logic [bb_pkg::PIX_W-1:0]     p1_q, p2_q;
  logic [EW-1:0]                w_ext, w_eff;
  logic [bb_pkg::SUM_W-1:0]     hsum;
  logic                         last_col, last_row;

  // Effective frame geometry
  always_comb begin
    w_ext = EW'(width_i);
    if (w_ext < EW'(3)) begin
      w_eff = EW'(3);
    end else if (w_ext > EW'(LINE_WIDTH)) begin
      w_eff = EW'(LINE_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    last_idx = AW'(w_eff - EW'(1));
    row_last = (height_i < 13'd3) ? 13'd2 : (height_i - 13'd1);
  end

  // Position of the current pixel
  always_comb begin
    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : row_q;
    col_cur  = (col_base >= last_idx) ? last_idx : col_base;
    last_col = (col_cur == last_idx);
    last_row = (row_base >= row_last);
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : (row_base + 13'd1);
    end else begin
      col_d = col_cur + AW'(1);
      row_d = row_base;
    end
  end

  // Horizontal mean of the last three pixels
  assign hsum    = bb_pkg::SUM_W'(p2_q) + bb_pkg::SUM_W'(p1_q) + bb_pkg::SUM_W'(pixel_i);
  assign hmean_o = bb_pkg::div3(hsum);
  assign col_o   = col_cur;

  // Only columns with a full horizontal window touch the line store
  assign push_o            = accept_i && (col_cur >= AW'(2));
  assign flags_o.emit      = (row_base >= 13'd2);
  assign flags_o.row_end   = last_col;
  assign flags_o.frame_end = last_col && last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      p1_q  <= '0;
      p2_q  <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
      p2_q  <= p1_q;
      p1_q  <= pixel_i;
    end
  end

endmodule

[rtl/bb_queue.sv]
`timescale 1ns / 1ps

module bb_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         pop_valid_o,
  output logic [W-1:0] pop_data_o
);

  localparam int PW = $clog2(bb_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(bb_pkg::QUEUE_DEPTH + 1);

  logic [W-1:0]  slot_q [bb_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q, count_d;
  logic          do_pop;

  assign do_pop      = pop_i && pop_valid_o;
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = slot_q[rd_ptr_q];
  assign full_o      = (count_q == CW'(bb_pkg::QUEUE_DEPTH));

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(bb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(bb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/bb_back.sv]
`timescale 1ns / 1ps

module bb_back #(
  parameter int LINE_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic [$clog2(LINE_WIDTH)-1:0] req_col_i,
  input  logic [bb_pkg::PIX_W-1:0]      req_hmean_i,
  input  bb_pkg::bb_flags_t             req_flags_i,
  output logic                          req_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bb_pkg::PIX_W-1:0]      blurred_o,
  output logic                          row_end_o,
  output logic                          frame_end_o
);

  localparam int AW = $clog2(LINE_WIDTH);
  localparam int DW = 2 * bb_pkg::PIX_W;

  // Line store: upper byte is two rows up, lower byte is one row up
  logic [DW-1:0]              line_mem [LINE_WIDTH];
  logic [DW-1:0]              rd_q, byp_q, s1_data, wdata;
  logic                       byp_sel_q;
  logic                       s1_v_q, s1_go, out_free;
  logic [AW-1:0]              s1_col_q;
  logic [bb_pkg::PIX_W-1:0]   s1_hm_q, above, above2, out_blur_q;
  bb_pkg::bb_flags_t          s1_flags_q;
  logic                       out_v_q, out_row_end_q, out_frame_end_q;
  logic [bb_pkg::SUM_W-1:0]   vsum;
  logic                       fwd;

  assign out_free  = !out_v_q || !out_stall_i;
  assign s1_go     = s1_v_q && (!s1_flags_q.emit || out_free);
  assign req_pop_o = req_valid_i && (!s1_v_q || s1_go);

  // A request that reads the column being written this cycle takes the new data
  assign fwd     = s1_go && (s1_col_q == req_col_i);
  assign s1_data = byp_sel_q ? byp_q : rd_q;
  assign above   = s1_data[bb_pkg::PIX_W-1:0];
  assign above2  = s1_data[DW-1:bb_pkg::PIX_W];
  assign wdata   = {above, s1_hm_q};
  assign vsum    = bb_pkg::SUM_W'(above2) + bb_pkg::SUM_W'(above) + bb_pkg::SUM_W'(s1_hm_q);

  // Line store read and write
  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      rd_q <= line_mem[req_col_i];
    end
    if (s1_go) begin
      line_mem[s1_col_q] <= wdata;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      s1_col_q   <= req_col_i;
      s1_hm_q    <= req_hmean_i;
      s1_flags_q <= req_flags_i;
      byp_q      <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      byp_sel_q <= 1'b0;
    end else begin
      if (req_pop_o) begin
        s1_v_q    <= 1'b1;
        byp_sel_q <= fwd;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_go && s1_flags_q.emit) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_flags_q.emit) begin
      out_blur_q      <= bb_pkg::div3(vsum);
      out_row_end_q   <= s1_flags_q.row_end;
      out_frame_end_q <= s1_flags_q.frame_end;
    end
  end

  assign out_valid_o = out_v_q;
  assign blurred_o   = out_blur_q;
  assign row_end_o   = out_row_end_q;
  assign frame_end_o = out_frame_end_q;

endmodule

[rtl/bb_checker.sv]
`timescale 1ns / 1ps

module bb_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     pready,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [bb_pkg::PIX_W-1:0] blurred_o,
  input logic                     row_end_o,
  input logic                     frame_end_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(blurred_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // The last result of a frame also closes its row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  // The config port never inserts wait states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind box_blur_3x3_stream_top bb_checker u_bb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .blurred_o   (blurred_o),
  .row_end_o   (row_end_o),
  .frame_end_o (frame_end_o)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LINE_W     = 1024;
  localparam logic [2:0]  ADDR_WIDTH  = {bb_pkg::REG_WIDTH, 2'b00};
  localparam logic [2:0]  ADDR_HEIGHT = {bb_pkg::REG_HEIGHT, 2'b00};

  // One blurred output as the block reports it
  typedef struct packed {
    logic [7:0] blurred;
    logic       row_end;
    logic       frame_end;
  } blur_result_t;

  // Predicts blurred outputs from accepted pixels and checks what comes out
  class blur_scoreboard;
    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    int unsigned  prev_px1, prev_px2;
    logic [7:0]   row_above[LINE_W];
    logic [7:0]   row_above2[LINE_W];
    int unsigned  col_cnt, row_cnt;
    blur_result_t blur_q[$];
    int           errors;

    function new();
      width_reg  = bb_pkg::WIDTH_RESET;
      height_reg = bb_pkg::HEIGHT_RESET;
      prev_px1   = 0;
      prev_px2   = 0;
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
      foreach (row_above[i]) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(input logic idx, input logic [31:0] value);
      if (idx == bb_pkg::REG_WIDTH) begin
        width_reg = value[10:0];
      end else begin
        height_reg = value[12:0];
      end
    endfunction

    function bit at_frame_origin();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function int unsigned pending();
      return blur_q.size();
    endfunction

    // Advance the window by one accepted pixel request
    function void note_pixel(input logic [7:0] px, input logic fs);
      int unsigned  w, h, col, hmean, up1, up2;
      bit           last_col;
      blur_result_t res;
      // out-of-range sizes are clamped
      w = width_reg;
      if (w < 3) w = 3;
      if (w > LINE_W) w = LINE_W;
      h = height_reg;
      if (h < 3) h = 3;
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      col = (col_cnt >= w - 1) ? w - 1 : col_cnt;
      last_col = (col == w - 1);
      if (col >= 2) begin
        hmean = (prev_px2 + prev_px1 + int'(px)) / 3;
        up1   = row_above[col];
        up2   = row_above2[col];
        if (row_cnt >= 2) begin
          res.blurred   = 8'((up2 + up1 + hmean) / 3);
          res.row_end   = last_col;
          res.frame_end = last_col && (row_cnt >= h - 1);
          blur_q.push_back(res);
        end
        row_above2[col] = up1[7:0];
        row_above[col]  = hmean[7:0];
      end
      prev_px2 = prev_px1;
      prev_px1 = px;
      // wrap at row end, and at frame end even without a new frame start
      if (last_col) begin
        col_cnt = 0;
        row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
      end else begin
        col_cnt = col + 1;
      end
    endfunction

    task check_result(input logic [7:0] blurred, input logic row_end,
                      input logic frame_end);
      blur_result_t exp_res;
      if (blur_q.size() == 0) begin
        report($sformatf("unexpected output blurred=%0d", blurred));
      end else begin
        exp_res = blur_q.pop_front();
        if (blurred !== exp_res.blurred)
          report($sformatf("blurred %0d, expected %0d", blurred, exp_res.blurred));
        if (row_end !== exp_res.row_end)
          report($sformatf("row_end %b, expected %b", row_end, exp_res.row_end));
        if (frame_end !== exp_res.frame_end)
          report($sformatf("frame_end %b, expected %b", frame_end, exp_res.frame_end));
      end
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_i       = '0;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  blurred_o;
  logic        row_end_o;
  logic        frame_end_o;

  blur_scoreboard sb = new();

  bit          calm         = 1'b0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned stall_left   = 0;

  box_blur_3x3_stream_top #(.LINE_WIDTH(LINE_W)) dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .pixel_i, .frame_start_i,
    .out_valid_o, .out_stall_i, .blurred_o, .row_end_o, .frame_end_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #(64'd20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Output side: random stall bursts, then check each accepted result
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
      stall_left = $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(blurred_o, row_end_o, frame_end_o);
  end

  function automatic int unsigned idle_level();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 40;
    endcase
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Two back-to-back register writes: width, then height
  task automatic program_size(input logic [31:0] w_val, input logic [31:0] h_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH;
    pwdata  <= w_val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(bb_pkg::REG_WIDTH, w_val);
    penable <= 1'b0;
    paddr   <= ADDR_HEIGHT;
    pwdata  <= h_val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(bb_pkg::REG_HEIGHT, h_val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drive one pixel request, with an optional idle burst ahead of it
  task automatic send_pixel(input logic [7:0] px, input logic fs);
    if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(px, fs);
  endtask

  // Let all results drain and the pipeline empty before touching registers
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // One setting of the frame size, then n pixels of mostly whole frames
  task automatic run_phase(input int unsigned w_wr, input int unsigned h_wr,
                           input int unsigned n, input int unsigned restart_pm);
    logic fs;
    wait_idle();
    program_size(32'(w_wr), 32'(h_wr));
    in_idle_pct  = idle_level();
    out_idle_pct = idle_level();
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) fs = 1'b1;
      else if (sb.at_frame_origin()) fs = ($urandom_range(0, 3) != 0);
      else fs = ($urandom_range(0, 999) < restart_pm);
      send_pixel(rand_pixel(), fs);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned w_wr, h_wr, ew, eh, n, small_items, drain;
    small_items = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: undersized registers clamp to a 3x3 frame
    program_size(32'd1, 32'd2);
    // saturated window, then a frame that wraps in without a start marker
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(8'h00, 1'b0);
    // restart at a frame boundary, then mid-frame
    send_pixel(8'h80, 1'b1);
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel(), i == 0);
    in_valid_i <= 1'b0;

    // Register extremes: zero width, tall frame, oversized width, zero height
    run_phase(0, 3, 3 * 3 * 3 + 2, 5);
    run_phase(3, 8191, 60, 5);
    run_phase(2047, 2, 40, 0);
    run_phase(4, 0, 4 * 3 * 2, 5);
    small_items = 25 + 29 + 60 + 40 + 24;

    // Random small frames, leaving room for the closing stretch
    while (small_items < 1080) begin
      w_wr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 20);
      h_wr = $urandom_range(0, 8);
      ew = (w_wr < 3) ? 3 : w_wr;
      eh = (h_wr < 3) ? 3 : h_wr;
      n = ew * eh * $urandom_range(1, 3) + $urandom_range(0, ew);
      run_phase(w_wr, h_wr, n, 5);
      small_items += n;
    end

    // Closing stretch at full rate
    wait_idle();
    calm = 1'b1;
    run_phase(7, 5, 7 * 5 * 2, 5);

    drain = 0;
    while (sb.pending() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected outputs never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
